[sv/rmts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared constants and register codes for the rate-monotonic tick scheduler.
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int unsigned NumTasksDef  = 4;
  localparam int unsigned TimeWidthDef = 16;
  localparam int unsigned TaskSlots    = 4;
  localparam int unsigned RegW         = 16;
  localparam int unsigned SlotW        = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned TaskIdxW     = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPeriod0 = 3'd0,
    CfgPeriod1 = 3'd1,
    CfgPeriod2 = 3'd2,
    CfgPeriod3 = 3'd3,
    CfgExec0   = 3'd4,
    CfgExec1   = 3'd5,
    CfgExec2   = 3'd6,
    CfgExec3   = 3'd7
  } cfg_idx_e;

endpackage

[sv/rate_monotonic_tick_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler_unit
// Four-task rate-monotonic scheduler, one scheduling decision per request.
// ----------------------------------------------------------------------------
//  channel | handshake                       | payload
//  --------+---------------------------------+---------------------------------
//  in      | in_valid_i / in_stall_o         | restart_i
//  out     | out_valid_o / out_stall_i       | time_slot_o, running_task_o,
//          |                                 | slot_idle_o, task_finished_o
//  cfg     | cfg_we_i                        | cfg_idx_i, cfg_data_i
//
//  one request per cycle while in_stall_o is low; its result is captured in the output register
//  the decision is one priority compare over the task periods plus counter updates
//  a new request is taken while the output register is empty or being drained
//  in_stall_o follows out_stall_i whenever a result is held
//  reset loads periods and exec times of 1, all tasks ready, remaining counts at 1, slot and phase counters at zero
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler_unit #(
  parameter int unsigned NUM_TASKS  = rmts_pkg::NumTasksDef,
  parameter int unsigned TIME_WIDTH = rmts_pkg::TimeWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rmts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rmts_pkg::RegW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rmts_pkg::SlotW-1:0]   time_slot_o,
  output logic [rmts_pkg::TaskIdxW-1:0] running_task_o,
  output logic                         slot_idle_o,
  output logic                         task_finished_o
);
  import rmts_pkg::*;

  localparam int unsigned CmpW = (TIME_WIDTH > RegW) ? TIME_WIDTH : RegW;

  logic [RegW-1:0]       period_q [TaskSlots];
  logic [RegW-1:0]       exec_q   [TaskSlots];

  logic [TIME_WIDTH-1:0] slot_q, slot_d;
  logic [NUM_TASKS-1:0]  ready_q, ready_d;
  logic [TIME_WIDTH-1:0] rem_q   [NUM_TASKS];
  logic [TIME_WIDTH-1:0] rem_d   [NUM_TASKS];
  logic [TIME_WIDTH-1:0] phase_q [NUM_TASKS];
  logic [TIME_WIDTH-1:0] phase_d [NUM_TASKS];

  logic                  out_valid_q;
  logic [SlotW-1:0]      time_slot_q, time_slot_d;
  logic [TaskIdxW-1:0]   task_q, task_d;
  logic                  idle_q, idle_d;
  logic                  fin_q, fin_d;

  logic                  accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TaskSlots; t++) begin
        period_q[t] <= RegW'(1);
        exec_q[t]   <= RegW'(1);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPeriod0: period_q[0] <= cfg_data_i;
        CfgPeriod1: period_q[1] <= cfg_data_i;
        CfgPeriod2: period_q[2] <= cfg_data_i;
        CfgPeriod3: period_q[3] <= cfg_data_i;
        CfgExec0:   exec_q[0]   <= cfg_data_i;
        CfgExec1:   exec_q[1]   <= cfg_data_i;
        CfgExec2:   exec_q[2]   <= cfg_data_i;
        CfgExec3:   exec_q[3]   <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // one slot of scheduling
  always_comb begin
    logic [NUM_TASKS-1:0]  rdy;
    logic [TIME_WIDTH-1:0] rem_eff;
    logic [TIME_WIDTH-1:0] rem_dec;
    logic [TIME_WIDTH-1:0] ph_eff;
    logic [TIME_WIDTH-1:0] ph_inc;
    logic [TIME_WIDTH-1:0] exec_tw;
    logic [TIME_WIDTH-1:0] slot_eff;
    logic [CmpW-1:0]       slot_ext;
    logic                  found;
    logic [TaskIdxW-1:0]   win;

    found    = 1'b0;
    win      = '0;
    fin_d    = 1'b0;
    slot_eff = restart_i ? '0 : slot_q;

    for (int t = 0; t < NUM_TASKS; t++) begin
      rdy[t] = restart_i | ready_q[t] | (phase_q[t] == '0);
    end

    for (int t = 0; t < NUM_TASKS; t++) begin
      if (rdy[t] && (!found || (period_q[t] < period_q[win]))) begin
        found = 1'b1;
        win   = TaskIdxW'(t);
      end
    end

    for (int t = 0; t < NUM_TASKS; t++) begin
      exec_tw  = TIME_WIDTH'(CmpW'(exec_q[t]));
      rem_eff  = restart_i ? exec_tw : rem_q[t];
      rem_dec  = rem_eff - TIME_WIDTH'(1);
      ready_d[t] = rdy[t];
      rem_d[t]   = rem_eff;
      if (found && (win == TaskIdxW'(t)) && (rem_eff != '0)) begin
        if (rem_dec == '0) begin
          ready_d[t] = 1'b0;
          rem_d[t]   = exec_tw;
          fin_d      = 1'b1;
        end else begin
          rem_d[t] = rem_dec;
        end
      end

      ph_eff = restart_i ? '0 : phase_q[t];
      ph_inc = ph_eff + TIME_WIDTH'(1);
      if (CmpW'(ph_inc) >= CmpW'(period_q[t])) begin
        phase_d[t] = '0;
      end else begin
        phase_d[t] = ph_inc;
      end
    end

    slot_d      = slot_eff + TIME_WIDTH'(1);
    slot_ext    = CmpW'(slot_eff);
    time_slot_d = slot_ext[SlotW-1:0];
    task_d      = win;
    idle_d      = ~found;
  end

  // schedule state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      ready_q     <= '1;
      out_valid_q <= 1'b0;
      for (int t = 0; t < NUM_TASKS; t++) begin
        rem_q[t]   <= TIME_WIDTH'(1);
        phase_q[t] <= '0;
      end
    end else begin
      if (accept) begin
        slot_q  <= slot_d;
        ready_q <= ready_d;
        for (int t = 0; t < NUM_TASKS; t++) begin
          rem_q[t]   <= rem_d[t];
          phase_q[t] <= phase_d[t];
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      time_slot_q <= time_slot_d;
      task_q      <= task_d;
      idle_q      <= idle_d;
      fin_q       <= fin_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign time_slot_o     = time_slot_q;
  assign running_task_o  = task_q;
  assign slot_idle_o     = idle_q;
  assign task_finished_o = fin_q;

endmodule

[sv/rmts_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmts_checker
// Port-level checks for the rate-monotonic tick scheduler.
// ----------------------------------------------------------------------------
module rmts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [rmts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input logic [rmts_pkg::RegW-1:0]     cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          restart_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rmts_pkg::SlotW-1:0]    time_slot_o,
  input logic [rmts_pkg::TaskIdxW-1:0] running_task_o,
  input logic                          slot_idle_o,
  input logic                          task_finished_o
);
  import rmts_pkg::*;

  // an accepted request always yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  // restart begins at slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && restart_i) |=> (time_slot_o == '0))
    else $error("restart did not begin at slot zero");

  // idle slot reports no task and no finish
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && slot_idle_o) |-> (running_task_o == '0 && !task_finished_o))
    else $error("idle slot reports a task");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(time_slot_o) &&
      $stable(running_task_o) && $stable(slot_idle_o) && $stable(task_finished_o)))
    else $error("stalled result changed");

endmodule

bind rate_monotonic_tick_scheduler_unit rmts_checker u_rmts_checker (.*);
